// ===== rtl/assert_macros.svh =====
// Assertion macros for the core RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with explicit clock and active-low reset.
`define ASSERT_CLKRST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion on the block's own clock and reset.
`define ASSERT_P(lbl, prop, msg) \
    `ASSERT_CLKRST(lbl, i_clk, i_rst_n, prop, msg)

`endif

// ===== rtl/usbep0_pkg.sv =====
// Package: codes, types and constants for the EP0 control-transfer sequencer.
`default_nettype none

package usbep0_pkg;

    // Event kinds carried on the input tuser.
    typedef enum logic [1:0] {
        EV_BUS_RESET = 2'd0,
        EV_SETUP     = 2'd1,
        EV_IN_DONE   = 2'd2,
        EV_OUT_DONE  = 2'd3
    } t_event;

    // Commands to the endpoint.
    typedef enum logic [1:0] {
        ACT_NONE  = 2'd0,
        ACT_TX    = 2'd1,
        ACT_RX    = 2'd2,
        ACT_STALL = 2'd3
    } t_action;

    // Transmit data source.
    typedef enum logic [1:0] {
        SRC_NONE   = 2'd0,
        SRC_STATUS = 2'd1,
        SRC_DESC   = 2'd2,
        SRC_CONFIG = 2'd3
    } t_source;

    // Control-transfer phases.
    typedef enum logic [2:0] {
        PH_WAIT_SETUP = 3'd0,
        PH_TX         = 3'd1,
        PH_RX         = 3'd2,
        PH_WAIT_STS   = 3'd3,
        PH_SEND_STS   = 3'd4,
        PH_ERROR      = 3'd5
    } t_phase;

    // Standard request codes.
    localparam logic [7:0] REQ_GET_STATUS     = 8'd0;
    localparam logic [7:0] REQ_SET_ADDRESS    = 8'd5;
    localparam logic [7:0] REQ_GET_DESCRIPTOR = 8'd6;
    localparam logic [7:0] REQ_GET_CONFIG     = 8'd8;
    localparam logic [7:0] REQ_SET_CONFIG     = 8'd9;
    localparam logic [7:0] REQ_SYNCH_FRAME    = 8'd12;

    // Recipients.
    localparam logic [4:0] RCP_DEVICE    = 5'd0;
    localparam logic [4:0] RCP_INTERFACE = 5'd1;
    localparam logic [4:0] RCP_ENDPOINT  = 5'd2;

    // Field widths.
    localparam int LEN_W   = 16;
    localparam int PKT_W   = 10;
    localparam int ADDR_W  = 7;
    localparam int CFG_W   = 8;
    localparam int SHIFT_W = 3;

    localparam logic [LEN_W-1:0]   LEN_STATUS   = 16'd2;
    localparam logic [LEN_W-1:0]   LEN_CONFIG   = 16'd1;
    localparam logic [LEN_W-1:0]   LEN_SETUP_RX = 16'd8;
    localparam logic [SHIFT_W-1:0] SHIFT_MIN    = 3'd3;
    localparam logic [SHIFT_W-1:0] SHIFT_MAX    = 3'd6;
    localparam logic [SHIFT_W-1:0] SHIFT_RESET  = 3'd6;
    localparam logic [PKT_W-1:0]   PKT_MAX      = 10'd1023;

    // One result item.
    typedef struct packed {
        logic [CFG_W-1:0]  config_value;
        logic [ADDR_W-1:0] device_address;
        t_phase            ctrl_phase;
        t_source           data_source;
        logic [PKT_W-1:0]  packet_count;
        logic [LEN_W-1:0]  xfer_length;
        t_action           action;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/usb_ep0_control_transfer_fsm_core.sv =====
// Top level: USB endpoint-zero control-transfer sequencer.
//
// Usage:
//   Events enter on the s_axis channel: tuser holds the event kind (bus
//   reset, setup received, IN complete, OUT complete), tdata holds the setup
//   fields, the descriptor length and the OUT byte count. Each event yields
//   exactly one result on the m_axis channel: a command (none, transmit,
//   receive, stall), byte and packet counts, the transmit data source, the
//   phase after the event, and the current device address and configuration.
//   The result passes through the input register and then the decode into
//   the result register. Throughput is one item per cycle while the receiver
//   takes each result; the state registers are the only loop and they close
//   through the decode logic. If the receiver stalls, the result register
//   holds and the input register still takes one more item; after that
//   s_axis_tready drops until the result is taken. Reset (synchronous,
//   active low) empties both registers, returns the phase to waiting for
//   setup, clears address and configuration and sets the packet size
//   register to 64 bytes. The user must write the packet size through
//   i_ep0_size_log2_we / i_ep0_size_log2 only while no item is in flight;
//   the block itself does not enforce this.
`default_nettype none

module usb_ep0_control_transfer_fsm_core
    import usbep0_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // packet size register write
    input  wire logic                 i_ep0_size_log2_we,
    input  wire logic [SHIFT_W-1:0]   i_ep0_size_log2,
    // event input
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    // [7:0] bm_request_type, [15:8] b_request, [31:16] w_value,
    // [47:32] w_length, [63:48] descriptor_length, [79:64] rx_count
    input  wire logic [79:0]          s_axis_tdata,
    // [1:0] event kind (t_event)
    input  wire logic [1:0]           s_axis_tuser,
    // result output
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    // [1:0] action, [17:2] xfer_length, [27:18] packet_count,
    // [29:28] data_source, [32:30] ctrl_phase, [39:33] device_address,
    // [47:40] config_value
    output logic [47:0]               m_axis_tdata
);

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    logic                 r_in_vld;
    logic [79:0]          r_in_data;
    t_event               r_in_ev;
    logic                 r_out_vld;
    t_result              r_out;

    logic [SHIFT_W-1:0]   r_size_log2;
    t_phase               r_phase;
    logic [LEN_W-1:0]     r_tx_length;
    logic [LEN_W-1:0]     r_saved_wlen;
    logic                 r_zlp_sent;
    logic [ADDR_W-1:0]    r_address;
    logic [CFG_W-1:0]     r_config;

    // next-state values
    t_phase               n_phase;
    logic [LEN_W-1:0]     n_tx_length;
    logic [LEN_W-1:0]     n_saved_wlen;
    logic                 n_zlp_sent;
    logic [ADDR_W-1:0]    n_address;
    logic [CFG_W-1:0]     n_config;
    t_result              n_out;

    logic                 w_adv;

    // input register fields
    logic [7:0]           w_bm;
    logic [7:0]           w_breq;
    logic [LEN_W-1:0]     w_wval;
    logic [LEN_W-1:0]     w_wlen;
    logic [LEN_W-1:0]     w_dlen;
    logic [LEN_W-1:0]     w_rx;

    // packet size
    logic [SHIFT_W-1:0]   w_shift;
    logic [6:0]           w_mask;

    // setup decode
    logic                 w_std_ok;
    logic [LEN_W-1:0]     w_req_len;
    t_source              w_req_src;
    logic                 w_set_addr;
    logic                 w_set_cfg;
    logic [LEN_W-1:0]     w_trim_len;

    // command before packet count
    t_action              w_act;
    logic [LEN_W-1:0]     w_len;
    t_source              w_src;
    logic [LEN_W:0]       w_round;
    logic [LEN_W:0]       w_quot;
    logic [PKT_W-1:0]     w_pkts;

    // result checks
    logic                 w_out_stall;
    logic                 w_out_empty_cmd;
    logic                 w_out_counts;
    logic                 w_out_has_src;
    logic                 w_out_tx_data;

    assign w_bm   = r_in_data[7:0];
    assign w_breq = r_in_data[15:8];
    assign w_wval = r_in_data[31:16];
    assign w_wlen = r_in_data[47:32];
    assign w_dlen = r_in_data[63:48];
    assign w_rx   = r_in_data[79:64];

    // result register frees up when empty or being taken
    assign w_adv         = !r_out_vld || m_axis_tready;
    assign s_axis_tready = !r_in_vld || w_adv;

    // clamp packet size to 8..64 bytes
    always_comb begin
        if (r_size_log2 < SHIFT_MIN) begin
            w_shift = SHIFT_MIN;
        end else if (r_size_log2 > SHIFT_MAX) begin
            w_shift = SHIFT_MAX;
        end else begin
            w_shift = r_size_log2;
        end
    end
    assign w_mask = 7'((7'd1 << w_shift) - 7'd1);

    // standard request decode by recipient
    always_comb begin
        w_std_ok   = 1'b0;
        w_req_len  = '0;
        w_req_src  = SRC_NONE;
        w_set_addr = 1'b0;
        w_set_cfg  = 1'b0;
        if (w_bm[4:0] == RCP_DEVICE) begin
            case (w_breq)
                REQ_GET_STATUS: begin
                    w_std_ok  = 1'b1;
                    w_req_len = LEN_STATUS;
                    w_req_src = SRC_STATUS;
                end
                REQ_SET_ADDRESS: begin
                    w_std_ok   = 1'b1;
                    w_set_addr = 1'b1;
                end
                REQ_GET_DESCRIPTOR: begin
                    w_std_ok  = (w_dlen != '0);
                    w_req_len = w_dlen;
                    w_req_src = SRC_DESC;
                end
                REQ_GET_CONFIG: begin
                    w_std_ok  = 1'b1;
                    w_req_len = LEN_CONFIG;
                    w_req_src = SRC_CONFIG;
                end
                REQ_SET_CONFIG: begin
                    w_std_ok  = 1'b1;
                    w_set_cfg = 1'b1;
                end
                default: begin
                    w_std_ok = 1'b0;
                end
            endcase
        end else if ((w_bm[4:0] == RCP_INTERFACE && w_breq == REQ_GET_STATUS) ||
                     (w_bm[4:0] == RCP_ENDPOINT && w_breq == REQ_SYNCH_FRAME)) begin
            w_std_ok  = 1'b1;
            w_req_len = LEN_STATUS;
            w_req_src = SRC_STATUS;
        end
        // vendor and class requests are never supported
        if (w_bm[6:5] != 2'b00) begin
            w_std_ok   = 1'b0;
            w_set_addr = 1'b0;
            w_set_cfg  = 1'b0;
        end
    end

    assign w_trim_len = (w_req_len > w_wlen) ? w_wlen : w_req_len;

    // phase update and command selection
    always_comb begin
        n_phase      = r_phase;
        n_tx_length  = r_tx_length;
        n_saved_wlen = r_saved_wlen;
        n_zlp_sent   = r_zlp_sent;
        n_address    = r_address;
        n_config     = r_config;
        w_act        = ACT_NONE;
        w_len        = '0;
        w_src        = SRC_NONE;
        case (r_in_ev)
            EV_BUS_RESET: begin
                n_phase      = PH_WAIT_SETUP;
                n_tx_length  = '0;
                n_saved_wlen = '0;
                n_zlp_sent   = 1'b0;
                n_address    = '0;
                n_config     = '0;
            end
            EV_SETUP: begin
                n_saved_wlen = w_wlen;
                n_zlp_sent   = 1'b0;
                if (!w_std_ok) begin
                    n_phase = PH_ERROR;
                    w_act   = ACT_STALL;
                end else begin
                    if (w_set_addr) begin
                        n_address = w_wval[ADDR_W-1:0];
                    end
                    if (w_set_cfg) begin
                        n_config = w_wval[CFG_W-1:0];
                    end
                    if (w_bm[7]) begin
                        if (w_trim_len != '0) begin
                            n_phase     = PH_TX;
                            n_tx_length = w_trim_len;
                            w_act       = ACT_TX;
                            w_len       = w_trim_len;
                            w_src       = w_req_src;
                        end else begin
                            n_phase = PH_WAIT_STS;
                            w_act   = ACT_RX;
                        end
                    end else begin
                        if (w_trim_len != '0) begin
                            n_phase = PH_RX;
                            w_act   = ACT_RX;
                            w_len   = w_trim_len;
                        end else begin
                            n_phase     = PH_SEND_STS;
                            n_tx_length = '0;
                            w_act       = ACT_TX;
                        end
                    end
                end
            end
            EV_IN_DONE: begin
                if (r_phase == PH_TX) begin
                    // short reply ending on a packet boundary: one zero-length packet
                    if (!r_zlp_sent && r_tx_length < r_saved_wlen &&
                        (r_tx_length[6:0] & w_mask) == '0) begin
                        n_zlp_sent = 1'b1;
                        w_act      = ACT_TX;
                    end else begin
                        n_phase = PH_WAIT_STS;
                        w_act   = ACT_RX;
                    end
                end else if (r_phase == PH_SEND_STS) begin
                    n_phase = PH_WAIT_SETUP;
                end else begin
                    n_phase = PH_ERROR;
                    w_act   = ACT_STALL;
                end
            end
            EV_OUT_DONE: begin
                if (r_phase == PH_RX) begin
                    n_phase     = PH_SEND_STS;
                    n_tx_length = '0;
                    w_act       = ACT_TX;
                end else if (r_phase == PH_WAIT_STS && w_rx == '0) begin
                    n_phase = PH_WAIT_SETUP;
                    w_act   = ACT_RX;
                    w_len   = LEN_SETUP_RX;
                end else begin
                    n_phase = PH_ERROR;
                    w_act   = ACT_STALL;
                end
            end
            default: begin
                n_phase = r_phase;
            end
        endcase
    end

    // packet count: ceil(len / size), 1 for zero length, saturated; 0 for none or stall
    assign w_round = {1'b0, w_len} + {10'd0, w_mask};
    assign w_quot  = w_round >> w_shift;
    always_comb begin
        if (w_act != ACT_TX && w_act != ACT_RX) begin
            w_pkts = '0;
        end else if (w_len == '0) begin
            w_pkts = PKT_W'(1);
        end else if (w_quot > {7'd0, PKT_MAX}) begin
            w_pkts = PKT_MAX;
        end else begin
            w_pkts = w_quot[PKT_W-1:0];
        end
    end

    always_comb begin
        n_out.action         = w_act;
        n_out.xfer_length    = w_len;
        n_out.packet_count   = w_pkts;
        n_out.data_source    = w_src;
        n_out.ctrl_phase     = n_phase;
        n_out.device_address = n_address;
        n_out.config_value   = n_config;
    end

    // ---------------------------------------------------------------
    // State and registered outputs
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld     <= 1'b0;
            r_out_vld    <= 1'b0;
            r_size_log2  <= SHIFT_RESET;
            r_phase      <= PH_WAIT_SETUP;
            r_tx_length  <= '0;
            r_saved_wlen <= '0;
            r_zlp_sent   <= 1'b0;
            r_address    <= '0;
            r_config     <= '0;
        end else begin
            if (i_ep0_size_log2_we) begin
                r_size_log2 <= i_ep0_size_log2;
            end
            if (s_axis_tready) begin
                r_in_vld  <= s_axis_tvalid;
                r_in_data <= s_axis_tdata;
                r_in_ev   <= t_event'(s_axis_tuser);
            end
            if (w_adv) begin
                r_out_vld <= r_in_vld;
                if (r_in_vld) begin
                    r_phase      <= n_phase;
                    r_tx_length  <= n_tx_length;
                    r_saved_wlen <= n_saved_wlen;
                    r_zlp_sent   <= n_zlp_sent;
                    r_address    <= n_address;
                    r_config     <= n_config;
                    r_out        <= n_out;
                end
            end
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    assign w_out_stall     = r_out_vld && r_out.action == ACT_STALL;
    assign w_out_empty_cmd = r_out_vld &&
                             (r_out.action == ACT_NONE || r_out.action == ACT_STALL);
    assign w_out_counts    = r_out.packet_count != '0 || r_out.xfer_length != '0;
    assign w_out_has_src   = r_out_vld && r_out.data_source != SRC_NONE;
    assign w_out_tx_data   = r_out.action == ACT_TX && r_out.xfer_length != '0;

`include "assert_macros.svh"

    `ASSERT_P(a_stall_is_error, w_out_stall |-> r_out.ctrl_phase == PH_ERROR, "stall phase")
    `ASSERT_P(a_idle_cmd_no_count, w_out_empty_cmd |-> !w_out_counts, "counts on empty command")
    `ASSERT_P(a_source_only_tx, w_out_has_src |-> w_out_tx_data, "source without transmit")
    `ASSERT_P(a_item_moves_out, w_adv && r_in_vld |=> r_out_vld, "item lost between stages")

endmodule

`default_nettype wire
